[rtl/lpr_pkg.sv]
package lpr_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PORT_W    = 4;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned CFG_W     = 7;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
  } route_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

[rtl/longest_prefix_route_lookup.sv]
// write item: accepted while idle, leaves the block ready, no result
// lookup item: scans table entries 0 to n-1, n = min(count, depth), then gives one result
// one table entry read a cycle while scanning; no new item is taken until the result is loaded for output
// reset (rst_ni low, asynchronous): sequencer idle, no result pending, entry count zero
// the routing table itself is not cleared; entries hold nothing defined until written
module longest_prefix_route_lookup
  import lpr_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              action_i,
  input  logic [SLOT_W-1:0] entry_index_i,
  input  logic [ADDR_W-1:0] entry_prefix_i,
  input  logic [ADDR_W-1:0] entry_mask_i,
  input  logic [ADDR_W-1:0] entry_next_hop_i,
  input  logic [PORT_W-1:0] entry_port_i,
  input  logic [ADDR_W-1:0] lookup_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              route_found_o,
  output logic [ADDR_W-1:0] route_next_hop_o,
  output logic [PORT_W-1:0] route_port_o,
  output logic [SLOT_W-1:0] route_index_o
);

  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned LIM_RW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LIM_W  = (LIM_RW > CFG_W) ? LIM_RW : CFG_W;
  localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(TABLE_DEPTH);

  route_entry_t mem [TABLE_DEPTH];
  route_entry_t rd_data_q;
  route_entry_t wr_entry;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  cfg_q;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [LIM_W-1:0]  lim_q, lim_d;
  logic [LIM_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic              found_q, found_d;
  logic [ADDR_W-1:0] best_mask_q, best_mask_d;
  logic [ADDR_W-1:0] best_hop_q, best_hop_d;
  logic [PORT_W-1:0] best_port_q, best_port_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;

  logic              out_valid_q, out_valid_d;
  logic              out_found_q, out_found_d;
  logic [ADDR_W-1:0] out_hop_q, out_hop_d;
  logic [PORT_W-1:0] out_port_q, out_port_d;
  logic [SLOT_W-1:0] out_idx_q, out_idx_d;

  logic              in_ready;
  logic              in_acc;
  logic              mem_we;
  logic              rd_en;
  logic              slot_ok;
  logic              scan_end;
  logic              out_free;
  logic              hit;
  logic [LIM_W-1:0]  cfg_ext;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [31:0]       best_idx_ext;

  assign wr_entry = '{prefix:   entry_prefix_i,
                      mask:     entry_mask_i,
                      gateway:  entry_next_hop_i,
                      port:     entry_port_i};
  assign slot_ok  = (32'(entry_index_i) < 32'(TABLE_DEPTH));
  assign wr_addr  = IDX_W'(entry_index_i);
  assign rd_addr  = rd_cnt_q[IDX_W-1:0];
  assign in_acc   = in_valid_i && in_ready;
  assign scan_end = (rd_cnt_q == lim_q) && !cmp_vld_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign cfg_ext  = LIM_W'(cfg_q);
  assign hit      = cmp_vld_q
                 && ((addr_q & rd_data_q.mask) == (rd_data_q.prefix & rd_data_q.mask))
                 && (!found_q || (rd_data_q.mask > best_mask_q));
  assign best_idx_ext = 32'(best_idx_q);

  // table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (action_i == ACT_LOOKUP)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        mem_we   = in_valid_i && (action_i == ACT_WRITE) && slot_ok;
      end
      ST_SCAN: begin
        rd_en = (rd_cnt_q < lim_q);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // scan datapath
  always_comb begin
    addr_d      = addr_q;
    lim_d       = lim_q;
    rd_cnt_d    = rd_cnt_q;
    cmp_vld_d   = rd_en;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    best_mask_d = best_mask_q;
    best_hop_d  = best_hop_q;
    best_port_d = best_port_q;
    best_idx_d  = best_idx_q;

    if (in_acc && (action_i == ACT_LOOKUP)) begin
      addr_d      = lookup_address_i;
      lim_d       = (cfg_ext > DEPTH_L) ? DEPTH_L : cfg_ext;
      rd_cnt_d    = '0;
      found_d     = 1'b0;
      best_mask_d = '0;
      best_hop_d  = '0;
      best_port_d = '0;
      best_idx_d  = '0;
    end

    if (rd_en) begin
      rd_cnt_d  = rd_cnt_q + LIM_W'(1);
      cmp_idx_d = rd_addr;
    end

    if (hit) begin
      found_d     = 1'b1;
      best_mask_d = rd_data_q.mask;
      best_hop_d  = rd_data_q.gateway;
      best_port_d = rd_data_q.port;
      best_idx_d  = cmp_idx_q;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_hop_d   = out_hop_q;
    out_port_d  = out_port_q;
    out_idx_d   = out_idx_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_valid_d = 1'b1;
      out_found_d = found_q;
      out_hop_d   = best_hop_q;
      out_port_d  = best_port_q;
      out_idx_d   = best_idx_ext[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= '0;
      rd_cnt_q    <= '0;
      lim_q       <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      lim_q       <= lim_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    cmp_idx_q   <= cmp_idx_d;
    best_mask_q <= best_mask_d;
    best_hop_q  <= best_hop_d;
    best_port_q <= best_port_d;
    best_idx_q  <= best_idx_d;
    out_found_q <= out_found_d;
    out_hop_q   <= out_hop_d;
    out_port_q  <= out_port_d;
    out_idx_q   <= out_idx_d;
  end

  assign in_ready_o       = in_ready;
  assign out_valid_o      = out_valid_q;
  assign route_found_o    = out_found_q;
  assign route_next_hop_o = out_hop_q;
  assign route_port_o     = out_port_q;
  assign route_index_o    = out_idx_q;

endmodule

[rtl/lpr_checker.sv]
module lpr_checker
  import lpr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              action_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              route_found_o,
  input logic [ADDR_W-1:0] route_next_hop_o,
  input logic [PORT_W-1:0] route_port_o,
  input logic [SLOT_W-1:0] route_index_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(route_found_o)
      && $stable(route_next_hop_o) && $stable(route_port_o) && $stable(route_index_o))
    else $error("result changed while stalled");

  // no route gives all-zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !route_found_o |->
      (route_next_hop_o == '0) && (route_port_o == '0) && (route_index_o == '0))
    else $error("miss result carries non-zero fields");

  // a lookup item busies the block
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_LOOKUP) |=> !in_ready_o)
    else $error("ready during lookup");

  // a write item leaves the block ready
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_WRITE) |=> in_ready_o)
    else $error("not ready after table write");

endmodule

bind longest_prefix_route_lookup lpr_checker u_lpr_checker (.*);

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import lpr_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned TAIL_CYCLES = TABLE_DEPTH + 16;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot;
    route_entry_t      entry;
    logic [ADDR_W-1:0] address;
  } route_req_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
    logic [SLOT_W-1:0] index;
  } route_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              action_i = ACT_WRITE;
  logic [SLOT_W-1:0] entry_index_i = '0;
  logic [ADDR_W-1:0] entry_prefix_i = '0;
  logic [ADDR_W-1:0] entry_mask_i = '0;
  logic [ADDR_W-1:0] entry_next_hop_i = '0;
  logic [PORT_W-1:0] entry_port_i = '0;
  logic [ADDR_W-1:0] lookup_address_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              route_found_o;
  logic [ADDR_W-1:0] route_next_hop_o;
  logic [PORT_W-1:0] route_port_o;
  logic [SLOT_W-1:0] route_index_o;

  route_entry_t      route_table [TABLE_DEPTH];
  logic [CFG_W-1:0]  scan_count = '0;
  route_result_t     expected_routes [$];
  int unsigned       errors = 0;
  bit                idle_en = 1'b1;
  int unsigned       holds_requested = 0;
  int unsigned       holds_served = 0;
  int unsigned       hold_left = 0;
  int unsigned       quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  longest_prefix_route_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .entry_index_i   (entry_index_i),
    .entry_prefix_i  (entry_prefix_i),
    .entry_mask_i    (entry_mask_i),
    .entry_next_hop_i(entry_next_hop_i),
    .entry_port_i    (entry_port_i),
    .lookup_address_i(lookup_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .route_found_o   (route_found_o),
    .route_next_hop_o(route_next_hop_o),
    .route_port_o    (route_port_o),
    .route_index_o   (route_index_o)
  );

  function automatic route_result_t lookup_route(input logic [ADDR_W-1:0] addr);
    route_result_t     res;
    logic [ADDR_W-1:0] best_mask;
    int unsigned       depth;
    res = '0;
    best_mask = '0;
    depth = (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : scan_count;
    for (int i = 0; i < depth; i++) begin
      if (((addr ^ route_table[i].prefix) & route_table[i].mask) == '0 &&
          (!res.found || route_table[i].mask > best_mask)) begin
        res.found = 1'b1;
        best_mask = route_table[i].mask;
        res.gateway = route_table[i].gateway;
        res.port = route_table[i].port;
        res.index = SLOT_W'(i);
      end
    end
    return res;
  endfunction

  function automatic route_entry_t make_entry(input logic [ADDR_W-1:0] prefix,
                                              input logic [ADDR_W-1:0] mask,
                                              input logic [ADDR_W-1:0] gateway,
                                              input logic [PORT_W-1:0] port);
    route_entry_t e;
    e.prefix = prefix;
    e.mask = mask;
    e.gateway = gateway;
    e.port = port;
    return e;
  endfunction

  function automatic route_entry_t random_route();
    int unsigned       plen;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] mask;
    case ($urandom_range(3))
      0: plen = 8 * $urandom_range(4);
      1, 2: plen = $urandom_range(32);
      default: plen = 33;
    endcase
    // beyond 32 stands for a scattered mask
    if (plen > 32) mask = $urandom;
    else mask = {ADDR_W{1'b1}} << (ADDR_W - plen);
    case ($urandom_range(2))
      0: base = {8'd10, 24'($urandom)};
      1: base = {16'hC0A8, 16'($urandom)};
      default: base = $urandom;
    endcase
    return make_entry(base, mask, $urandom, PORT_W'($urandom_range(15)));
  endfunction

  function automatic route_req_t make_write(input int unsigned slot, input route_entry_t e);
    route_req_t req;
    req.action = ACT_WRITE;
    req.slot = SLOT_W'(slot);
    req.entry = e;
    req.address = $urandom;
    return req;
  endfunction

  function automatic route_req_t make_lookup(input logic [ADDR_W-1:0] addr);
    route_req_t req;
    req.action = ACT_LOOKUP;
    req.slot = SLOT_W'($urandom);
    req.entry = make_entry($urandom, $urandom, $urandom, PORT_W'($urandom));
    req.address = addr;
    return req;
  endfunction

  // mostly addresses that fall inside some stored prefix
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned  slot;
    route_entry_t e;
    slot = $urandom_range(TABLE_DEPTH - 1);
    e = route_table[slot];
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? '1 : '0;
      default: return (e.prefix & e.mask) | (ADDR_W'($urandom) & ~e.mask);
    endcase
  endfunction

  task automatic issue_request(input route_req_t req);
    while (idle_en && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= req.action;
    entry_index_i <= req.slot;
    entry_prefix_i <= req.entry.prefix;
    entry_mask_i <= req.entry.mask;
    entry_next_hop_i <= req.entry.gateway;
    entry_port_i <= req.entry.port;
    lookup_address_i <= req.address;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (req.action == ACT_LOOKUP) expected_routes.push_back(lookup_route(req.address));
    else route_table[req.slot] = req.entry;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_route_count(input int unsigned n);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CFG_W'(n);
    @(posedge clk_i);
    scan_count = CFG_W'(n);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_mixed(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(99) < 20) begin
        issue_request(make_write($urandom_range(TABLE_DEPTH - 1), random_route()));
      end else begin
        issue_request(make_lookup(pick_address()));
      end
    end
  endtask

  task automatic test_empty_table();
    issue_request(make_lookup('0));
    issue_request(make_lookup('1));
  endtask

  task automatic test_directed_routes();
    issue_request(make_write(0, make_entry(32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 4'd1)));
    issue_request(make_write(1, make_entry(32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 4'd2)));
    // same prefix and mask as slot 1, lower slot must win
    issue_request(make_write(2, make_entry(32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0002, 4'd3)));
    // default route
    issue_request(make_write(3, make_entry(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15)));
    issue_request(make_write(4, make_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0)));
    // scattered mask, compared as a plain number
    issue_request(make_write(5, make_entry(32'h0A00_00FF, 32'hFF00_00FF, 32'h5555_AAAA, 4'd9)));
    issue_request(make_write(63, make_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_5555, 4'd15)));
    set_route_count(6);
    issue_request(make_lookup(32'h0A01_0203));
    issue_request(make_lookup(32'h0A02_0304));
    issue_request(make_lookup(32'hC0A8_0001));
    issue_request(make_lookup(32'hFFFF_FFFF));
    issue_request(make_lookup(32'h0A02_00FF));
    issue_request(make_lookup(32'h0000_0000));
    set_route_count(1);
    issue_request(make_lookup(32'h0B00_0000));
    issue_request(make_lookup(32'h0AFF_FFFF));
  endtask

  task automatic test_table_fill();
    for (int i = 0; i < TABLE_DEPTH; i++) issue_request(make_write(i, random_route()));
  endtask

  task automatic test_count_settings();
    set_route_count(TABLE_DEPTH);
    run_mixed(250);
    // beyond the table, the scan saturates
    set_route_count(127);
    run_mixed(250);
    set_route_count(1);
    run_mixed(150);
    set_route_count(33);
    run_mixed(250);
  endtask

  task automatic test_backpressure();
    set_route_count(8);
    holds_requested++;
    repeat (40) issue_request(make_lookup(pick_address()));
  endtask

  task automatic test_no_idle();
    set_route_count(TABLE_DEPTH);
    idle_en = 1'b0;
    run_mixed(200);
    wait_idle();
    idle_en = 1'b1;
  endtask

  task automatic test_random_counts();
    repeat (3) begin
      set_route_count($urandom_range(127));
      run_mixed(100);
    end
  endtask

  always @(posedge clk_i) begin : result_sink
    if (hold_left == 0 && holds_served != holds_requested) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(idle_en && $urandom_range(99) < 29);
    end
  end

  task automatic compare_field(input string name, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : route_monitor
    route_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_routes.size() == 0) begin
        $display("%0t: unexpected result, expected none actual found %b hop %h port %h slot %h",
                 $time, route_found_o, route_next_hop_o, route_port_o, route_index_o);
        errors++;
      end else begin
        want = expected_routes.pop_front();
        compare_field("route_found", ADDR_W'(want.found), ADDR_W'(route_found_o));
        compare_field("route_next_hop", want.gateway, route_next_hop_o);
        compare_field("route_port", ADDR_W'(want.port), ADDR_W'(route_port_o));
        compare_field("route_index", ADDR_W'(want.index), ADDR_W'(route_index_o));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[longest_prefix_route_lookup] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_directed_routes();
    test_table_fill();
    test_count_settings();
    test_backpressure();
    test_no_idle();
    test_random_counts();
    wait_idle();
    if (errors == 0) begin
      $display("[longest_prefix_route_lookup] OK");
    end else begin
      $display("[longest_prefix_route_lookup] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lpr_pkg.sv
rtl/longest_prefix_route_lookup.sv
rtl/lpr_checker.sv
tb/tb.sv
